[rtl/core/kmrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrb_pkg: shared definitions for the key matrix report builder
// Codes, widths and the control structs between the top level and list unit.
// ----------------------------------------------------------------------------
package kmrb_pkg;

  localparam int KEY_COUNT_DEF  = 128;
  localparam int LIST_SLOTS_DEF = 6;
  localparam int REPORT_SLOTS   = 6;

  localparam int CODE_W     = 8;
  localparam int KEY_W      = 7;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = CODE_W * (REPORT_SLOTS + 1);

  localparam logic [CODE_W-1:0] EMPTY_CODE = 8'hFF;
  localparam logic [CODE_W-1:0] NO_KEY     = 8'h00;
  // modifier codes 224..231 share this upper prefix
  localparam logic [4:0]        MOD_PREFIX = 5'b11100;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef struct packed {
    logic              start;
    logic              push;
    logic [CODE_W-1:0] code;
  } list_cmd_t;

  typedef struct packed {
    logic busy;
  } list_sts_t;

endpackage

[rtl/core/kmrb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kmrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/kmrb_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrb_list: held key list with a one-slot-per-cycle compare and shift unit
// Push shifts all slots down together; remove walks the slots in order.
// ----------------------------------------------------------------------------
module kmrb_list #(
  parameter int LIST_SLOTS = kmrb_pkg::LIST_SLOTS_DEF
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  kmrb_pkg::list_cmd_t                                cmd_i,
  output kmrb_pkg::list_sts_t                                sts_o,
  output logic [kmrb_pkg::REPORT_SLOTS-1:0][kmrb_pkg::CODE_W-1:0] slots_o
);

  localparam int EW = $clog2(LIST_SLOTS + 1);
  localparam logic [EW-1:0] LAST_IDX = EW'(LIST_SLOTS - 1);

  logic [kmrb_pkg::CODE_W-1:0] list_q [LIST_SLOTS];
  logic [kmrb_pkg::CODE_W-1:0] ext    [LIST_SLOTS + 1];
  logic [kmrb_pkg::CODE_W-1:0] code_q;
  logic [EW-1:0]               idx_q;
  logic [EW-1:0]               idx_nxt;
  logic                        busy_q;
  logic                        found_q;
  logic                        hit;

  always_comb begin
    for (int j = 0; j < LIST_SLOTS; j++) begin
      ext[j] = list_q[j];
    end
    ext[LIST_SLOTS] = kmrb_pkg::EMPTY_CODE;
  end

  assign idx_nxt = idx_q + EW'(1);
  assign hit     = found_q || (ext[idx_q] == code_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < LIST_SLOTS; j++) begin
        list_q[j] <= kmrb_pkg::EMPTY_CODE;
      end
      busy_q  <= 1'b0;
      found_q <= 1'b0;
      idx_q   <= '0;
      code_q  <= '0;
    end else if (busy_q) begin
      // shift up from the first match onward
      for (int j = 0; j < LIST_SLOTS; j++) begin
        if (hit && (EW'(j) == idx_q)) begin
          list_q[j] <= ext[idx_nxt];
        end
      end
      found_q <= hit;
      if (idx_q == LAST_IDX) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_nxt;
      end
    end else if (cmd_i.start) begin
      if (cmd_i.push) begin
        for (int j = LIST_SLOTS - 1; j > 0; j--) begin
          list_q[j] <= list_q[j-1];
        end
        list_q[0] <= cmd_i.code;
      end else begin
        busy_q  <= 1'b1;
        found_q <= 1'b0;
        idx_q   <= '0;
        code_q  <= cmd_i.code;
      end
    end
  end

  assign sts_o.busy = busy_q;

  for (genvar g = 0; g < kmrb_pkg::REPORT_SLOTS; g++) begin : g_slot
    if (g < LIST_SLOTS) begin : g_used
      assign slots_o[g] = (list_q[g] == kmrb_pkg::EMPTY_CODE) ? kmrb_pkg::NO_KEY : list_q[g];
    end else begin : g_unused
      assign slots_o[g] = kmrb_pkg::NO_KEY;
    end
  end

endmodule

[rtl/core/key_matrix_report_builder.sv]
`timescale 1ns / 1ps
// A load or an out-of-range word is taken in ST_IDLE alone; a sample reads the
// keymap RAM and is checked in ST_LOOKUP. A non-modifier key edge then waits in
// ST_WAIT until the list compare unit is idle, and every key edge ends in
// ST_REPORT, which holds while the output stalls.
// Throughput: one word at a time; ready returns with the report word.
// Reset: held bits and modifiers clear, list slots read empty, keymap undefined.
// ----------------------------------------------------------------------------
// key_matrix_report_builder: matrix sample to keyboard report builder
// Tracks key edges, keymap, modifier byte and held list; emits one report word.
// ----------------------------------------------------------------------------
module key_matrix_report_builder #(
  parameter int KEY_COUNT  = kmrb_pkg::KEY_COUNT_DEF,
  parameter int LIST_SLOTS = kmrb_pkg::LIST_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key_number[6:0], level[7], usage_code[15:8]
  input  logic [kmrb_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // cmd[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // modifiers[7:0], slot0[15:8] .. slot5[55:48]
  output logic [kmrb_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int KAW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WAIT,
    ST_REPORT
  } state_e;

  state_e                                               state_q;
  logic [KEY_COUNT-1:0]                                 held_q;
  logic [KAW-1:0]                                       key_q;
  logic                                                 level_q;
  logic [kmrb_pkg::CODE_W-1:0]                          mod_q;
  logic                                                 tvalid_q;
  logic [kmrb_pkg::M_TDATA_W-1:0]                       tdata_q;

  logic                                                 accept;
  logic                                                 in_range;
  logic [KAW-1:0]                                       key_addr;
  logic [kmrb_pkg::CODE_W-1:0]                          code;
  logic                                                 is_mod;
  logic                                                 press_go;
  logic                                                 rel_go;
  kmrb_pkg::list_cmd_t                                  list_cmd;
  kmrb_pkg::list_sts_t                                  list_sts;
  logic [kmrb_pkg::REPORT_SLOTS-1:0][kmrb_pkg::CODE_W-1:0] slots;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign key_addr      = KAW'(s_axis_tdata[kmrb_pkg::KEY_W-1:0]);
  assign in_range      = (9'(s_axis_tdata[kmrb_pkg::KEY_W-1:0]) < 9'(KEY_COUNT));

  kmrb_ram #(
    .WIDTH (kmrb_pkg::CODE_W),
    .DEPTH (KEY_COUNT)
  ) u_keymap (
    .clk_i   (clk_i),
    .we_i    (accept && in_range && (s_axis_tuser == kmrb_pkg::CMD_LOAD)),
    .waddr_i (key_addr),
    .wdata_i (s_axis_tdata[15:8]),
    .re_i    (accept && in_range && (s_axis_tuser == kmrb_pkg::CMD_SAMPLE)),
    .raddr_i (key_addr),
    .rdata_o (code)
  );

  assign is_mod   = (code[7:3] == kmrb_pkg::MOD_PREFIX);
  assign press_go = (code != kmrb_pkg::NO_KEY) && level_q && !held_q[key_q];
  assign rel_go   = (code != kmrb_pkg::NO_KEY) && !level_q && held_q[key_q];

  always_comb begin
    list_cmd.start = (state_q == ST_LOOKUP) && (press_go || rel_go) && !is_mod;
    list_cmd.push  = press_go;
    list_cmd.code  = code;
  end

  kmrb_list #(
    .LIST_SLOTS (LIST_SLOTS)
  ) u_list (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (list_cmd),
    .sts_o   (list_sts),
    .slots_o (slots)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      held_q   <= '0;
      key_q    <= '0;
      level_q  <= 1'b0;
      mod_q    <= '0;
      tvalid_q <= 1'b0;
      tdata_q  <= '0;
    end else begin
      if (tvalid_q && m_axis_tready && (state_q != ST_REPORT)) begin
        tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            key_q   <= key_addr;
            level_q <= s_axis_tdata[kmrb_pkg::KEY_W];
            if (in_range && (s_axis_tuser == kmrb_pkg::CMD_SAMPLE)) begin
              state_q <= ST_LOOKUP;
            end
          end
        end
        ST_LOOKUP: begin
          state_q <= ST_IDLE;
          if (press_go) begin
            held_q[key_q] <= 1'b1;
            if (is_mod) begin
              mod_q[code[2:0]] <= 1'b1;
              state_q          <= ST_REPORT;
            end else begin
              state_q <= ST_WAIT;
            end
          end else if (rel_go) begin
            held_q[key_q] <= 1'b0;
            if (is_mod) begin
              mod_q[code[2:0]] <= 1'b0;
              state_q          <= ST_REPORT;
            end else begin
              state_q <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (!list_sts.busy) begin
            state_q <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (!tvalid_q || m_axis_tready) begin
            tdata_q  <= {slots, mod_q};
            tvalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for key_matrix_report_builder
// Sends keymap loads and matrix samples and tracks the pressed keys, keymap,
// modifier byte and rollover list in its own model. Every report word is
// checked field by field against the oldest predicted report. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import kmrb_pkg::*;

  localparam int KEYS       = KEY_COUNT_DEF;
  localparam int SLOTS      = LIST_SLOTS_DEF;
  localparam int RAND_WORDS = 780;
  localparam int CYCLE_CAP  = 200000;

  typedef struct packed {
    logic [REPORT_SLOTS-1:0][CODE_W-1:0] slots;
    logic [CODE_W-1:0]                   mods;
  } kb_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_valid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_ready = 1'b0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  bit                   idle_en = 1'b1;
  bit                   stall_en = 1'b1;
  int                   err_count = 0;
  int                   words_sent = 0;
  int                   loads_sent = 0;
  int                   reports_seen = 0;
  int                   cycle_count = 0;

  // model state
  bit                   key_down [KEYS];
  logic [CODE_W-1:0]    keymap_copy [KEYS];
  logic [CODE_W-1:0]    roll_list [SLOTS+1];
  logic [CODE_W-1:0]    mod_byte;
  bit                   key_known [KEYS];
  int                   known_keys [$];
  kb_report_t           due_reports [$];

  always #10 clk_i = ~clk_i;

  key_matrix_report_builder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic bit apply_matrix_word(input logic cmd, input logic [KEY_W-1:0] key,
                                           input logic lvl, input logic [CODE_W-1:0] usage,
                                           output kb_report_t rpt);
    logic [CODE_W-1:0] code;
    int                i;
    int                j;
    rpt = '0;
    if (cmd == CMD_LOAD) begin
      keymap_copy[key] = usage;
      return 1'b0;
    end
    code = keymap_copy[key];
    if (code == NO_KEY) return 1'b0;
    if (lvl == key_down[key]) return 1'b0;
    key_down[key] = lvl;
    if (code[7:3] == MOD_PREFIX) begin
      mod_byte[code[2:0]] = lvl;
    end else if (lvl) begin
      for (i = SLOTS - 1; i > 0; i--) roll_list[i] = roll_list[i-1];
      roll_list[0] = code;
    end else begin
      i = 0;
      while (i < SLOTS && roll_list[i] != code) i++;
      for (; i < SLOTS; i++) roll_list[i] = roll_list[i+1];
    end
    rpt.mods = mod_byte;
    for (j = 0; j < REPORT_SLOTS; j++) begin
      rpt.slots[j] = (j < SLOTS && roll_list[j] != EMPTY_CODE) ? roll_list[j] : NO_KEY;
    end
    return 1'b1;
  endfunction

  task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic lvl, input logic [CODE_W-1:0] code);
    kb_report_t rpt;
    bit         fires;
    if (idle_en) begin
      while ($urandom_range(0, 99) < 10) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {code, lvl, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fires = apply_matrix_word(cmd, key, lvl, code, rpt);
    words_sent++;
    if (fires) begin
      due_reports.push_back(rpt);
    end
    if (cmd == CMD_LOAD) begin
      loads_sent++;
      if (!key_known[key]) begin
        key_known[key] = 1'b1;
        known_keys.push_back(key);
      end
    end
  endtask

  task automatic wait_drained;
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (due_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic release_held_keys;
    for (int k = 0; k < KEYS; k++) begin
      if (key_down[k]) send_word(CMD_SAMPLE, KEY_W'(k), 1'b0, '0);
    end
  endtask

  task automatic test_directed;
    send_word(CMD_LOAD, 7'd0, 1'b0, 8'h04);
    send_word(CMD_LOAD, 7'd127, 1'b1, 8'd224);
    send_word(CMD_LOAD, 7'd64, 1'b0, 8'd231);
    send_word(CMD_LOAD, 7'd2, 1'b1, EMPTY_CODE);
    send_word(CMD_LOAD, 7'd3, 1'b0, NO_KEY);
    for (int k = 4; k <= 8; k++) send_word(CMD_LOAD, KEY_W'(k), 1'b0, CODE_W'(8'h1A + k));
    send_word(CMD_SAMPLE, 7'd127, 1'b1, 8'hFF);
    send_word(CMD_SAMPLE, 7'd64, 1'b1, 8'h00);
    send_word(CMD_SAMPLE, 7'd0, 1'b1, 8'h00);
    send_word(CMD_SAMPLE, 7'd0, 1'b1, 8'h00);
    send_word(CMD_SAMPLE, 7'd3, 1'b1, 8'h00);
    send_word(CMD_SAMPLE, 7'd2, 1'b1, 8'h00);
    for (int k = 4; k <= 8; k++) send_word(CMD_SAMPLE, KEY_W'(k), 1'b1, 8'h00);
    send_word(CMD_SAMPLE, 7'd0, 1'b0, 8'h00);
    send_word(CMD_LOAD, 7'd8, 1'b0, 8'h1E);
    send_word(CMD_SAMPLE, 7'd8, 1'b0, 8'h00);
    send_word(CMD_SAMPLE, 7'd127, 1'b0, 8'h00);
    send_word(CMD_SAMPLE, 7'd0, 1'b0, 8'h00);
  endtask

  task automatic test_drain_pause;
    int key;
    repeat (3) begin
      repeat (4) begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        send_word(CMD_SAMPLE, KEY_W'(key), ~key_down[key], CODE_W'($urandom));
      end
      wait_drained();
    end
  endtask

  task automatic test_random_typing;
    int          start_sent;
    int          n;
    int          pick;
    int          key;
    logic [7:0]  usage;
    logic        lvl;
    start_sent = words_sent;
    n = 0;
    while (words_sent - start_sent < RAND_WORDS) begin
      n++;
      idle_en  = !(n >= 300 && n < 450);
      stall_en = idle_en;
      if (n % 130 == 0) release_held_keys();
      pick = $urandom_range(0, 99);
      if (pick < 15 || known_keys.size() == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2: usage = {MOD_PREFIX, 3'($urandom)};
          3:       usage = NO_KEY;
          4:       usage = EMPTY_CODE;
          5:       usage = 8'($urandom);
          default: usage = 8'($urandom_range(1, 16));
        endcase
        key = $urandom_range(0, 1) ? $urandom_range(0, KEYS - 1) : $urandom_range(0, 23);
        send_word(CMD_LOAD, KEY_W'(key), 1'($urandom), usage);
      end else begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        lvl = (pick < 85) ? ~key_down[key] : 1'($urandom);
        send_word(CMD_SAMPLE, KEY_W'(key), lvl, 8'($urandom));
      end
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
    release_held_keys();
  endtask

  always @(posedge clk_i) begin : report_check
    kb_report_t got;
    kb_report_t want;
    if (rst_n && m_axis_tvalid && m_ready) begin
      got = kb_report_t'(m_axis_tdata);
      reports_seen++;
      if (due_reports.size() == 0) begin
        $display("%0t: report with none due, expected none, actual %014h",
                 $time, m_axis_tdata);
        err_count++;
      end else begin
        want = due_reports.pop_front();
        if (got.mods !== want.mods) begin
          $display("%0t: modifiers mismatch, expected %02h, actual %02h",
                   $time, want.mods, got.mods);
          err_count++;
        end
        for (int j = 0; j < REPORT_SLOTS; j++) begin
          if (got.slots[j] !== want.slots[j]) begin
            $display("%0t: slot%0d mismatch, expected %02h, actual %02h",
                     $time, j, want.slots[j], got.slots[j]);
            err_count++;
          end
        end
      end
    end
    m_ready <= !stall_en || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("** key_matrix_report_builder: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < KEYS; k++) begin
      key_down[k]    = 1'b0;
      keymap_copy[k] = NO_KEY;
      key_known[k]   = 1'b0;
    end
    for (int k = 0; k <= SLOTS; k++) roll_list[k] = EMPTY_CODE;
    mod_byte = '0;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_drain_pause();
    test_random_typing();

    wait_drained();
    repeat (4 * (SLOTS + 2)) @(posedge clk_i);
    if (due_reports.size() != 0) begin
      $display("%0t: reports still due, expected 0, actual %0d",
               $time, due_reports.size());
      err_count++;
    end
    $display("Sent %0d words (%0d keymap loads) with press, release, repeat and remap cases;",
             words_sent, loads_sent);
    $display("checked %0d reports, %0d field mismatches.", reports_seen, err_count);
    if (err_count == 0) begin
      $display("** key_matrix_report_builder: PASSED **");
    end else begin
      $display("** key_matrix_report_builder: FAILED **");
    end
    $finish;
  end

endmodule
